@@ hw/rtl/ldcc_pkg.sv @@
// ============================================================================
// ldcc_pkg : shared types and constants of the letter / digram counter
// Beat layouts, table entry layouts, write records and register codes.
// ============================================================================
package ldcc_pkg;

	localparam int ALPHABET_SIZE = 128;
	localparam int COUNT_WIDTH   = 16;

	localparam int SYM_W     = 7;
	localparam int CNT_W     = COUNT_WIDTH;
	localparam int CONTACT_W = 8;
	localparam int LINK_W    = 7;
	localparam int TOTAL_W   = 32;
	localparam int OUT_CNT_W = 16;
	localparam int MADDR_W   = 2 * SYM_W;
	localparam int M_DEPTH   = 1 << MADDR_W;
	localparam int S_DEPTH   = 1 << SYM_W;
	localparam int APB_AW    = 3;
	localparam int PEND_MAX  = 2;

	localparam logic [SYM_W-1:0] NO_PREV = SYM_W'(127);

	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] N_LETTERS = 8'd26;
	localparam logic [7:0] N_DIGITS  = 8'd10;

	localparam logic [1:0] MODE_LETTER = 2'd0;
	localparam logic [1:0] MODE_DIGIT  = 2'd1;
	localparam logic [1:0] MODE_RAW    = 2'd2;

	typedef enum logic {
		OP_FEED = 1'b0,
		OP_READ = 1'b1
	} ldcc_op_t;

	typedef enum logic {
		REG_SYMBOL_MODE = 1'b0,
		REG_PAIRED      = 1'b1
	} ldcc_reg_t;

	typedef struct packed {
		logic [1:0] symbol_mode;
		logic       paired_digrams;
	} ldcc_cfg_t;

	typedef struct packed {
		logic             opcode;
		logic [7:0]       char_code;
		logic [SYM_W-1:0] first_symbol;
		logic [SYM_W-1:0] second_symbol;
	} ldcc_in_t;

	typedef struct packed {
		logic                 accepted;
		logic [SYM_W-1:0]     symbol_index;
		logic [OUT_CNT_W-1:0] symbol_count;
		logic [CONTACT_W-1:0] contact_count;
		logic [LINK_W-1:0]    distinct_preceders;
		logic [LINK_W-1:0]    distinct_followers;
		logic [OUT_CNT_W-1:0] pair_count;
		logic [OUT_CNT_W-1:0] digram_count;
		logic [TOTAL_W-1:0]   total_symbols;
	} ldcc_out_t;

	// one matrix word: follow and digram entries of a pair
	typedef struct packed {
		logic [CNT_W-1:0] follow;
		logic [CNT_W-1:0] digram;
	} ldcc_ment_t;

	// one symbol word
	typedef struct packed {
		logic [CNT_W-1:0]     occ;
		logic [CONTACT_W-1:0] contact;
		logic [LINK_W-1:0]    prec;
		logic [LINK_W-1:0]    foll;
	} ldcc_sent_t;

	typedef struct packed {
		logic               en;
		logic [MADDR_W-1:0] addr;
		ldcc_ment_t         data;
	} ldcc_mwr_t;

	typedef struct packed {
		logic             en;
		logic [SYM_W-1:0] addr;
		ldcc_sent_t       data;
	} ldcc_swr_t;

	// decoded item as it travels down the pipe
	typedef struct packed {
		ldcc_op_t           op;
		logic               sym_ok;
		logic               has_prev;
		logic               dig_en;
		logic [SYM_W-1:0]   sym;
		logic [SYM_W-1:0]   prev;
		logic [SYM_W-1:0]   second;
		logic [TOTAL_W-1:0] total;
	} ldcc_item_t;

	// matrix address of the first read: the requested pair, or prev then fed
	function automatic logic [MADDR_W-1:0] maddr_first(ldcc_item_t it);
		logic [MADDR_W-1:0] a;
		if (it.op == OP_READ) begin
			a = {it.sym, it.second};
		end else begin
			a = {it.prev, it.sym};
		end
		return a;
	endfunction

endpackage

@@ hw/rtl/ldcc_ram.sv @@
// ============================================================================
// ldcc_ram : generic single-write, single-read synchronous RAM
// Read data is registered; a read in the cycle of a write returns old data.
// ============================================================================
module ldcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/ldcc_cfg_regs.sv @@
// ============================================================================
// ldcc_cfg_regs : APB register file
// Holds the symbol class and the paired digram switch.
// ============================================================================
module ldcc_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ldcc_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output ldcc_pkg::ldcc_cfg_t        cfg
);
	import ldcc_pkg::*;

	ldcc_cfg_t cfg_q;
	ldcc_reg_t idx;
	logic      wr;

	assign idx    = ldcc_reg_t'(paddr[APB_AW-1]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_SYMBOL_MODE: cfg_q.symbol_mode    <= pwdata[1:0];
				REG_PAIRED:      cfg_q.paired_digrams <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SYMBOL_MODE: prdata = 32'(cfg_q.symbol_mode);
			REG_PAIRED:      prdata = 32'(cfg_q.paired_digrams);
		endcase
	end

endmodule

@@ hw/rtl/ldcc_update.sv @@
// ============================================================================
// ldcc_update : forwarding and update arithmetic of the write-back stage
// Patches stale read data from recent writes, computes new entries and the
// result beat.
// ============================================================================
module ldcc_update (
	input  logic                   valid,
	input  ldcc_pkg::ldcc_item_t   item,
	input  ldcc_pkg::ldcc_ment_t   m_first,
	input  ldcc_pkg::ldcc_sent_t   s_first,
	input  ldcc_pkg::ldcc_ment_t   m_second,
	input  ldcc_pkg::ldcc_sent_t   s_second,
	input  ldcc_pkg::ldcc_mwr_t    mh1,
	input  ldcc_pkg::ldcc_mwr_t    mh2,
	input  ldcc_pkg::ldcc_swr_t    sh1,
	input  ldcc_pkg::ldcc_swr_t    sh2,
	output ldcc_pkg::ldcc_mwr_t    m_wr,
	output ldcc_pkg::ldcc_swr_t    s_wr,
	output ldcc_pkg::ldcc_swr_t    p_wr,
	output ldcc_pkg::ldcc_out_t    res
);
	import ldcc_pkg::*;

	function automatic ldcc_ment_t fwd_m(ldcc_ment_t raw, logic [MADDR_W-1:0] addr,
			ldcc_mwr_t h1, ldcc_mwr_t h2);
		ldcc_ment_t v;
		v = raw;
		if (h1.en && h1.addr == addr) begin
			v = h1.data;
		end else if (h2.en && h2.addr == addr) begin
			v = h2.data;
		end
		return v;
	endfunction

	function automatic ldcc_sent_t fwd_s(ldcc_sent_t raw, logic [SYM_W-1:0] addr,
			ldcc_swr_t h1, ldcc_swr_t h2);
		ldcc_sent_t v;
		v = raw;
		if (h1.en && h1.addr == addr) begin
			v = h1.data;
		end else if (h2.en && h2.addr == addr) begin
			v = h2.data;
		end
		return v;
	endfunction

	function automatic logic [CNT_W-1:0] sat_cnt(logic [CNT_W-1:0] v);
		return (&v) ? v : v + CNT_W'(1);
	endfunction

	function automatic logic [CONTACT_W-1:0] sat_ct(logic [CONTACT_W-1:0] v);
		return (&v) ? v : v + CONTACT_W'(1);
	endfunction

	function automatic logic [LINK_W-1:0] sat_ln(logic [LINK_W-1:0] v);
		return (&v) ? v : v + LINK_W'(1);
	endfunction

	function automatic logic [OUT_CNT_W-1:0] clip(logic [CNT_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[OUT_CNT_W-1:0];
	endfunction

	ldcc_ment_t pc, cp, pc_n;
	ldcc_sent_t ce, pe, ce_n, pe_n;
	logic       self_pair, new_pc, new_ct, feed, upd;

	always_comb begin
		// first reads are patched from both write history entries; second reads from the newer one only
		pc = fwd_m(m_first, maddr_first(item), mh1, mh2);
		cp = fwd_m(m_second, {item.sym, item.prev}, mh1, '0);
		ce = fwd_s(s_first, item.sym, sh1, sh2);
		pe = fwd_s(s_second, item.prev, sh1, '0);

		feed      = item.op == OP_FEED;
		upd       = valid && feed && item.sym_ok;
		self_pair = item.prev == item.sym;
		new_pc    = pc.follow == '0;
		new_ct    = new_pc && cp.follow == '0;

		pc_n.follow = sat_cnt(pc.follow);
		pc_n.digram = item.dig_en ? sat_cnt(pc.digram) : pc.digram;

		ce_n     = ce;
		ce_n.occ = sat_cnt(ce.occ);
		pe_n     = pe;
		if (item.has_prev) begin
			if (new_ct) begin
				// a self pair meets itself from both sides
				ce_n.contact = self_pair ? sat_ct(sat_ct(ce.contact)) : sat_ct(ce.contact);
				pe_n.contact = sat_ct(pe.contact);
			end
			if (new_pc) begin
				ce_n.prec = sat_ln(ce.prec);
				if (self_pair) begin
					ce_n.foll = sat_ln(ce.foll);
				end
				pe_n.foll = sat_ln(pe.foll);
			end
		end

		m_wr.en   = upd && item.has_prev;
		m_wr.addr = {item.prev, item.sym};
		m_wr.data = pc_n;
		s_wr.en   = upd;
		s_wr.addr = item.sym;
		s_wr.data = ce_n;
		p_wr.en   = upd && item.has_prev && !self_pair;
		p_wr.addr = item.prev;
		p_wr.data = pe_n;

		res               = '0;
		res.total_symbols = item.total;
		if (!feed) begin
			res.accepted     = 1'b1;
			res.symbol_index = item.sym;
			if ({1'b0, item.sym} < (SYM_W+1)'(ALPHABET_SIZE)) begin
				res.symbol_count       = clip(ce.occ);
				res.contact_count      = ce.contact;
				res.distinct_preceders = ce.prec;
				res.distinct_followers = ce.foll;
				if ({1'b0, item.second} < (SYM_W+1)'(ALPHABET_SIZE)) begin
					res.pair_count   = clip(pc.follow);
					res.digram_count = clip(pc.digram);
				end
			end
		end else if (item.sym_ok) begin
			res.accepted           = 1'b1;
			res.symbol_index       = item.sym;
			res.symbol_count       = clip(ce_n.occ);
			res.contact_count      = ce_n.contact;
			res.distinct_preceders = ce_n.prec;
			res.distinct_followers = ce_n.foll;
			if (item.has_prev) begin
				res.pair_count   = clip(pc_n.follow);
				res.digram_count = clip(pc_n.digram);
			end
		end
	end

endmodule

@@ hw/rtl/ldcc_out_fifo.sv @@
// ============================================================================
// ldcc_out_fifo : two-beat result buffer
// Parts the write-back stage from a stalled result channel.
// ============================================================================
module ldcc_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ldcc_pkg::ldcc_out_t push_data,
	input  logic                pop,
	output logic                valid,
	output ldcc_pkg::ldcc_out_t head
);
	import ldcc_pkg::*;

	logic [1:0] cnt_q;
	ldcc_out_t  head_q, next_q;

	assign valid = cnt_q != 2'd0;
	assign head  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= (cnt_q == 2'(PEND_MAX)) ? next_q : push_data;
			if (push && cnt_q == 2'(PEND_MAX)) begin
				next_q <= push_data;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				next_q <= push_data;
			end
		end
	end

endmodule

@@ hw/rtl/letter_digram_contact_counter.sv @@
// ============================================================================
// letter_digram_contact_counter : symbol, digram and contact statistics
// Counts characters per symbol class and keeps follow, digram and contact
// tables in two synchronous memories with read-modify-write and forwarding.
// ============================================================================
// Pipe: a taken beat passes stage 1 and the write-back stage, which pushes its
//   result beat into the result buffer. Each item makes two read passes on the
//   single read port of the pair matrix (p,c then c,p); no new beat is taken
//   while an item is in its first phase. Reset: prev symbol, total and registers
//   clear at once; a clearing pass then zeroes both memories, and the feed
//   channel stalls until it ends. Configuration writes are taken throughout.
module letter_digram_contact_counter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        feed_valid,
	output logic                        feed_stall,
	input  ldcc_pkg::ldcc_in_t          feed_data,
	output logic                        result_valid,
	input  logic                        result_stall,
	output ldcc_pkg::ldcc_out_t         result_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ldcc_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import ldcc_pkg::*;

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	ldcc_cfg_t cfg;

	ldcc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ------------------------------------------------------------------
	// Declarations
	// ------------------------------------------------------------------
	logic               clr_busy_q;
	logic [MADDR_W-1:0] clr_idx_q;
	logic [SYM_W-1:0]   prev_q;
	logic [TOTAL_W-1:0] total_q;
	logic [1:0]         pend_q;

	logic               valid_s1, ph_s1, valid_s2;
	ldcc_item_t         item_d, item_s1, item_s2;
	ldcc_ment_t         m_pc_s2;
	ldcc_sent_t         s_c_s2;
	ldcc_swr_t          pwr_s3;

	ldcc_mwr_t          mh1_q, mh2_q, m_wr, upd_m_wr;
	ldcc_swr_t          sh1_q, sh2_q, s_wr, upd_s_wr, upd_p_wr;
	ldcc_ment_t         m_rdata;
	ldcc_sent_t         s_rdata;
	logic [MADDR_W-1:0] m_raddr;
	logic [SYM_W-1:0]   s_raddr;
	ldcc_out_t          res;

	logic [7:0]         ch, low_ch;
	logic               is_dig, is_let, alnum, in_class, sym_ok;
	logic [SYM_W-1:0]   sym_c;
	logic [TOTAL_W-1:0] total_inc;
	logic               acc, pop;

	// ------------------------------------------------------------------
	// Character decode: fold case by the space bit, then range-check the
	// offset from 'a' or '0'. Mode 3 falls through to raw codes.
	// ------------------------------------------------------------------
	always_comb begin
		ch     = feed_data.char_code;
		low_ch = ch | CH_SPACE;
		is_dig = 8'(ch - CH_ZERO) < N_DIGITS;
		is_let = 8'(low_ch - CH_LA) < N_LETTERS;
		alnum  = is_dig || is_let;
		case (cfg.symbol_mode)
			MODE_LETTER: begin
				in_class = is_let;
				sym_c    = SYM_W'(low_ch - CH_LA);
			end
			MODE_DIGIT: begin
				in_class = is_dig;
				sym_c    = SYM_W'(ch - CH_ZERO);
			end
			MODE_RAW: begin
				in_class = 1'b1;
				sym_c    = ch[SYM_W-1:0];
			end
			default: begin
				in_class = 1'b1;
				sym_c    = ch[SYM_W-1:0];
			end
		endcase
		sym_ok    = alnum && in_class && ({1'b0, sym_c} < (SYM_W+1)'(ALPHABET_SIZE));
		total_inc = total_q + TOTAL_W'(1);
	end

	// Build the pipe item. Previous symbol and total are settled here, at
	// acceptance, so the next beat sees them without waiting for write-back.
	always_comb begin
		item_d          = '0;
		item_d.op       = ldcc_op_t'(feed_data.opcode);
		item_d.total    = total_q;
		item_d.second   = feed_data.second_symbol;
		if (item_d.op == OP_READ) begin
			item_d.sym = feed_data.first_symbol;
		end else begin
			item_d.sym      = sym_c;
			item_d.prev     = prev_q;
			item_d.has_prev = prev_q != NO_PREV;
			item_d.sym_ok   = sym_ok;
			if (sym_ok) begin
				item_d.total = total_inc;
			end
			// paired mode drops digrams that land on an odd total
			item_d.dig_en = !(cfg.paired_digrams && total_inc[0]);
		end
	end

	// ------------------------------------------------------------------
	// Handshake. After clearing, take a beat while stage 1 is empty or in its
	// second phase, and while at most one result is owed (or one leaves).
	// ------------------------------------------------------------------
	assign pop        = result_valid && !result_stall;
	assign feed_stall = clr_busy_q || (valid_s1 && !ph_s1) ||
		(pend_q == 2'(PEND_MAX) && !pop);
	assign acc        = feed_valid && !feed_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= NO_PREV;
			total_q <= '0;
			pend_q  <= '0;
		end else begin
			pend_q <= 2'(pend_q + {1'b0, acc} - {1'b0, pop});
			if (acc && item_d.op == OP_FEED) begin
				if (!alnum) begin
					// a break: drop adjacency
					prev_q <= NO_PREV;
				end else if (sym_ok) begin
					prev_q  <= sym_c;
					total_q <= total_inc;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Clearing pass after reset: one matrix word and one symbol word a
	// cycle; the symbol table sees its 128 words rewritten many times.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + MADDR_W'(1);
			if (clr_idx_q == MADDR_W'(M_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipe control. Stage 1 holds an item for two phases: phase 0 reads
	// the first pair and the fed (or requested) symbol, phase 1 reads the
	// reversed pair and the previous symbol. Stage 2 writes back the pair
	// and fed symbol; stage 3 writes back the previous symbol.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ph_s1    <= 1'b0;
			valid_s2 <= 1'b0;
			pwr_s3   <= '0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (ph_s1) begin
				valid_s1 <= 1'b0;
			end
			ph_s1    <= acc ? 1'b0 : (valid_s1 && !ph_s1);
			valid_s2 <= valid_s1 && ph_s1;
			pwr_s3   <= upd_p_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= item_d;
		end
		if (valid_s1 && ph_s1) begin
			// phase 0 data has landed: hold it alongside the item
			item_s2 <= item_s1;
			m_pc_s2 <= m_rdata;
			s_c_s2  <= s_rdata;
		end
	end

	// ------------------------------------------------------------------
	// Memory ports
	// ------------------------------------------------------------------
	always_comb begin
		if (ph_s1) begin
			m_raddr = {item_s1.sym, item_s1.prev};
			s_raddr = item_s1.prev;
		end else begin
			m_raddr = maddr_first(item_s1);
			s_raddr = item_s1.sym;
		end
	end

	// stages 2 and 3 of successive items never meet, so one port suffices
	always_comb begin
		if (clr_busy_q) begin
			m_wr.en   = 1'b1;
			m_wr.addr = clr_idx_q;
			m_wr.data = '0;
			s_wr.en   = 1'b1;
			s_wr.addr = clr_idx_q[SYM_W-1:0];
			s_wr.data = '0;
		end else begin
			m_wr = upd_m_wr;
			s_wr = upd_s_wr.en ? upd_s_wr : pwr_s3;
		end
	end

	// write history, two registers deep, for patching stale reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mh1_q <= '0;
			mh2_q <= '0;
			sh1_q <= '0;
			sh2_q <= '0;
		end else begin
			mh1_q <= m_wr;
			mh2_q <= mh1_q;
			sh1_q <= s_wr;
			sh2_q <= sh1_q;
		end
	end

	ldcc_ram #(
		.WIDTH ($bits(ldcc_ment_t)),
		.DEPTH (M_DEPTH)
	) u_pair_ram (
		.clk   (clk),
		.we    (m_wr.en),
		.waddr (m_wr.addr),
		.wdata (m_wr.data),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	ldcc_ram #(
		.WIDTH ($bits(ldcc_sent_t)),
		.DEPTH (S_DEPTH)
	) u_sym_ram (
		.clk   (clk),
		.we    (s_wr.en),
		.waddr (s_wr.addr),
		.wdata (s_wr.data),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// ------------------------------------------------------------------
	// Write-back stage
	// ------------------------------------------------------------------
	ldcc_update u_upd (
		.valid    (valid_s2),
		.item     (item_s2),
		.m_first  (m_pc_s2),
		.s_first  (s_c_s2),
		.m_second (m_rdata),
		.s_second (s_rdata),
		.mh1      (mh1_q),
		.mh2      (mh2_q),
		.sh1      (sh1_q),
		.sh2      (sh2_q),
		.m_wr     (upd_m_wr),
		.s_wr     (upd_s_wr),
		.p_wr     (upd_p_wr),
		.res      (res)
	);

	// ------------------------------------------------------------------
	// Result buffer
	// ------------------------------------------------------------------
	ldcc_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s2),
		.push_data (res),
		.pop       (pop),
		.valid     (result_valid),
		.head      (result_data)
	);

endmodule

@@ test/letter_digram_contact_counter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_digram_contact_counter_test : self-checking bench of the counter
// Drives character and read beats under random gaps and back-pressure,
// predicts every result beat from a private copy of the statistics tables
// and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module letter_digram_contact_counter_test;
	import ldcc_pkg::*;

	// Mode code the block does not name; it must behave as the raw mode.
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// Idle odds per side, in percent.
	localparam int IDLE_PCT = 32;

	// Cycles for which the result side holds off during the fill-up test.
	localparam int HOLD_CYCLES = 400;

	// Cycles to watch after the last result for anything unexpected.
	localparam int TAIL_CYCLES = 16;

	// Slowest correct run: the clearing pass, about 1850 beats plus sender gaps
	// and receiver stalls, one long hold-off and the APB traffic. The limit
	// is ten times a generous bound on such a run.
	localparam int CYCLE_LIMIT = 400000;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        feed_valid   = 1'b0;
	logic        feed_stall;
	ldcc_in_t    feed_data    = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	ldcc_out_t   result_data;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [APB_AW-1:0] paddr  = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;

	// Set to drop the random gaps on both sides.
	bit quiet = 1'b0;
	// Set to make the result side hold off for HOLD_CYCLES.
	bit hold_request = 1'b0;

	int mismatch_count = 0;
	int cycle_count    = 0;

	// Private copy of the statistics tables, the registers and the total.
	bit [CNT_W-1:0]     follow_tab  [S_DEPTH][S_DEPTH];
	bit [CNT_W-1:0]     digram_tab  [S_DEPTH][S_DEPTH];
	bit [CNT_W-1:0]     occ_tab     [S_DEPTH];
	bit [CONTACT_W-1:0] contact_tab [S_DEPTH];
	bit [LINK_W-1:0]    prec_tab    [S_DEPTH];
	bit [LINK_W-1:0]    foll_tab    [S_DEPTH];
	logic [SYM_W-1:0]   prev_sym  = NO_PREV;
	logic [TOTAL_W-1:0] sym_total = '0;
	ldcc_cfg_t          cfg       = '0;

	// Result beats still to come, oldest first.
	ldcc_out_t awaited_stats [$];

	letter_digram_contact_counter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.feed_valid   (feed_valid),
		.feed_stall   (feed_stall),
		.feed_data    (feed_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a lost beat or a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("letter_digram_contact_counter_test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("%0t ns mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
	endtask

	// ------------------------------------------------------------------
	// Character classes
	// ------------------------------------------------------------------
	function automatic bit is_letter(input logic [7:0] ch);
		// fold the case bit, then test the lower-case range
		return (ch | CH_SPACE) >= CH_LA && (ch | CH_SPACE) < CH_LA + N_LETTERS;
	endfunction

	function automatic bit is_digit(input logic [7:0] ch);
		return ch >= CH_ZERO && ch < CH_ZERO + N_DIGITS;
	endfunction

	function automatic bit is_alnum(input logic [7:0] ch);
		return is_letter(ch) || is_digit(ch);
	endfunction

	// Map an alphanumeric character to its symbol under a mode; tell
	// whether it belongs to the class at all.
	function automatic bit decode_char(input logic [7:0] ch, input logic [1:0] mode,
			output logic [SYM_W-1:0] sym);
		logic [7:0] wide;
		bit         in_class;
		case (mode)
			MODE_LETTER: begin
				in_class = is_letter(ch);
				wide     = (ch | CH_SPACE) - CH_LA;
			end
			MODE_DIGIT: begin
				in_class = is_digit(ch);
				wide     = ch - CH_ZERO;
			end
			default: begin
				// raw and spare modes take the code as it stands
				in_class = 1'b1;
				wide     = ch;
			end
		endcase
		sym = wide[SYM_W-1:0];
		return in_class && int'(wide) < ALPHABET_SIZE;
	endfunction

	// ------------------------------------------------------------------
	// Statistics predictor: advance the tables by one accepted beat and
	// queue the result beat it must produce.
	// ------------------------------------------------------------------
	task automatic tally_beat(input ldcc_in_t beat);
		ldcc_out_t        r;
		logic [SYM_W-1:0] c;
		logic [SYM_W-1:0] p;
		logic [SYM_W-1:0] a;
		logic [SYM_W-1:0] b;
		r = '0;
		if (beat.opcode == OP_READ) begin
			a = beat.first_symbol;
			b = beat.second_symbol;
			r.accepted           = 1'b1;
			r.symbol_index       = a;
			r.symbol_count       = occ_tab[a];
			r.contact_count      = contact_tab[a];
			r.distinct_preceders = prec_tab[a];
			r.distinct_followers = foll_tab[a];
			r.pair_count         = follow_tab[a][b];
			r.digram_count       = digram_tab[a][b];
		end else if (!is_alnum(beat.char_code)) begin
			// punctuation, space, control or high codes break adjacency
			prev_sym = NO_PREV;
		end else if (decode_char(beat.char_code, cfg.symbol_mode, c)) begin
			if (occ_tab[c] != '1) occ_tab[c]++;
			sym_total++;
			if (prev_sym != NO_PREV) begin
				p = prev_sym;
				// a new contact in either direction; a self pair bumps twice
				if (follow_tab[p][c] == 0 && follow_tab[c][p] == 0) begin
					if (contact_tab[p] != '1) contact_tab[p]++;
					if (contact_tab[c] != '1) contact_tab[c]++;
				end
				if (follow_tab[p][c] == 0) begin
					if (prec_tab[c] != '1) prec_tab[c]++;
					if (foll_tab[p] != '1) foll_tab[p]++;
				end
				if (follow_tab[p][c] != '1) follow_tab[p][c]++;
				// paired mode skips digrams that end on an odd total
				if (!(cfg.paired_digrams && sym_total[0]) && digram_tab[p][c] != '1)
					digram_tab[p][c]++;
				r.pair_count   = follow_tab[p][c];
				r.digram_count = digram_tab[p][c];
			end
			prev_sym = c;
			r.accepted           = 1'b1;
			r.symbol_index       = c;
			r.symbol_count       = occ_tab[c];
			r.contact_count      = contact_tab[c];
			r.distinct_preceders = prec_tab[c];
			r.distinct_followers = foll_tab[c];
		end
		// alphanumerics outside the class fall through: nothing counted,
		// previous symbol kept
		r.total_symbols = sym_total;
		awaited_stats.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls, one long hold-off on request, and the
	// field-by-field comparison at each taken beat.
	// ------------------------------------------------------------------
	always begin
		@(negedge clk);
		if (hold_request) begin
			result_stall <= 1'b1;
			repeat (HOLD_CYCLES - 1) @(negedge clk);
			hold_request = 1'b0;
		end else if (quiet) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin : result_check
		ldcc_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_stats.size() == 0) begin
				report_mismatch("result beat with nothing outstanding");
			end else begin
				want = awaited_stats.pop_front();
				check_field("accepted", 32'(result_data.accepted), 32'(want.accepted));
				check_field("symbol_index", 32'(result_data.symbol_index),
					32'(want.symbol_index));
				check_field("symbol_count", 32'(result_data.symbol_count),
					32'(want.symbol_count));
				check_field("contact_count", 32'(result_data.contact_count),
					32'(want.contact_count));
				check_field("distinct_preceders", 32'(result_data.distinct_preceders),
					32'(want.distinct_preceders));
				check_field("distinct_followers", 32'(result_data.distinct_followers),
					32'(want.distinct_followers));
				check_field("pair_count", 32'(result_data.pair_count),
					32'(want.pair_count));
				check_field("digram_count", 32'(result_data.digram_count),
					32'(want.digram_count));
				check_field("total_symbols", result_data.total_symbols,
					want.total_symbols);
			end
		end
	end

	// ------------------------------------------------------------------
	// Feed side
	// ------------------------------------------------------------------
	// Called at a falling edge; returns at the falling edge after the beat
	// is taken, with valid still high so back-to-back beats need no dip.
	task automatic send_beat(input ldcc_in_t beat);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			feed_valid <= 1'b0;
			@(negedge clk);
		end
		feed_valid <= 1'b1;
		feed_data  <= beat;
		do @(posedge clk); while (feed_stall);
		@(negedge clk);
		tally_beat(beat);
	endtask

	// Drop valid and wait for every outstanding result beat.
	task automatic await_drain();
		feed_valid <= 1'b0;
		do @(negedge clk); while (awaited_stats.size() != 0);
	endtask

	function automatic ldcc_in_t feed_beat(input logic [7:0] ch);
		ldcc_in_t b;
		b.opcode        = OP_FEED;
		b.char_code     = ch;
		// unused on a feed; toggle them anyway
		b.first_symbol  = SYM_W'($urandom_range(127));
		b.second_symbol = SYM_W'($urandom_range(127));
		return b;
	endfunction

	function automatic ldcc_in_t read_beat(input logic [SYM_W-1:0] lead,
			input logic [SYM_W-1:0] trail);
		ldcc_in_t b;
		b.opcode        = OP_READ;
		b.char_code     = 8'($urandom_range(255));
		b.first_symbol  = lead;
		b.second_symbol = trail;
		return b;
	endfunction

	// A random character of the class, biased to a few symbols so that
	// pairs repeat and contacts build up.
	function automatic logic [7:0] class_char(input logic [1:0] mode);
		int k;
		case (mode)
			MODE_LETTER: begin
				k = $urandom_range(1) ? $urandom_range(5) : $urandom_range(25);
				return ($urandom_range(1) ? CH_LA : (CH_LA ^ CH_SPACE)) + 8'(k);
			end
			MODE_DIGIT: begin
				return CH_ZERO + 8'($urandom_range(9));
			end
			default: begin
				k = $urandom_range(1) ? $urandom_range(7) : $urandom_range(61);
				if (k < 10)
					return CH_ZERO + 8'(k);
				else if (k < 36)
					return (CH_LA ^ CH_SPACE) + 8'(k - 10);
				else
					return CH_LA + 8'(k - 36);
			end
		endcase
	endfunction

	// Any character that breaks adjacency; spaces are the common case.
	function automatic logic [7:0] noise_char();
		logic [7:0] ch;
		if ($urandom_range(2) == 0)
			return CH_SPACE;
		do ch = 8'($urandom_range(255)); while (is_alnum(ch));
		return ch;
	endfunction

	// Half the reads hit symbols the class can produce, half go anywhere.
	function automatic logic [SYM_W-1:0] pick_read_symbol(input logic [1:0] mode);
		logic [SYM_W-1:0] sym;
		if ($urandom_range(1))
			return SYM_W'($urandom_range(127));
		void'(decode_char(class_char(mode), mode, sym));
		return sym;
	endfunction

	// Words of class characters with a sprinkling of foreign alphanumerics
	// and stray breaks, each word closed by a separator and now and then
	// followed by a read.
	task automatic send_words(input logic [1:0] mode, input int beats);
		int sent;
		int len;
		int roll;
		logic [7:0] ch;
		sent = 0;
		while (sent < beats) begin
			len = $urandom_range(1, 8);
			repeat (len) begin
				roll = $urandom_range(99);
				if (roll < 80)
					ch = class_char(mode);
				else if (roll < 90)
					ch = class_char(MODE_RAW);
				else
					ch = noise_char();
				send_beat(feed_beat(ch));
			end
			sent += len;
			if ($urandom_range(9) < 3) begin
				send_beat(read_beat(pick_read_symbol(mode), pick_read_symbol(mode)));
				sent++;
			end
			send_beat(feed_beat(noise_char()));
			sent++;
		end
	endtask

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	// Write one register, then read it back. Called at a falling edge with
	// the bus idle; returns with the bus idle again.
	task automatic write_reg(input ldcc_reg_t idx, input logic [31:0] val);
		logic [31:0] mask;
		mask = (idx == REG_SYMBOL_MODE) ? 32'h3 : 32'h1;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(4 * int'(idx));
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_SYMBOL_MODE)
			cfg.symbol_mode = val[1:0];
		else
			cfg.paired_digrams = val[0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (val & mask))
			report_mismatch($sformatf("register %s reads %0h, wrote %0h",
				idx.name(), prdata, val));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Let the block go idle, then set both registers.
	task automatic set_config(input logic [1:0] mode, input logic paired);
		await_drain();
		write_reg(REG_SYMBOL_MODE, 32'(mode));
		write_reg(REG_PAIRED, 32'(paired));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Registers take writes while the memories are still being cleared.
	task automatic test_registers();
		write_reg(REG_SYMBOL_MODE, 32'(MODE_SPARE));
		write_reg(REG_PAIRED, 32'h1);
		write_reg(REG_SYMBOL_MODE, 32'(MODE_RAW));
		write_reg(REG_SYMBOL_MODE, 32'(MODE_DIGIT));
		write_reg(REG_PAIRED, 32'h0);
		write_reg(REG_SYMBOL_MODE, 32'(MODE_LETTER));
	endtask

	task automatic test_directed();
		set_config(MODE_LETTER, 1'b0);
		send_beat(feed_beat("a"));          // no previous symbol yet
		send_beat(feed_beat("A"));          // folds onto a: self pair
		send_beat(feed_beat("5"));          // digit outside the class, a kept
		send_beat(feed_beat("z"));          // a then z
		send_beat(feed_beat("!"));          // break
		send_beat(feed_beat("Z"));
		send_beat(feed_beat(8'hFF));        // high code breaks too
		send_beat(feed_beat(8'h00));
		send_beat(feed_beat("m"));
		send_beat(read_beat('0, '0));
		send_beat(read_beat('1, '1));       // a symbol no character reaches
		send_beat(read_beat(SYM_W'(25), '0));

		set_config(MODE_DIGIT, 1'b1);
		send_beat(feed_beat("0"));
		send_beat(feed_beat("9"));
		send_beat(feed_beat("q"));          // letter outside the class
		send_beat(feed_beat("9"));
		send_beat(feed_beat(CH_SPACE));
		send_beat(feed_beat("0"));

		set_config(MODE_RAW, 1'b0);
		send_beat(feed_beat("Q"));
		send_beat(feed_beat("q"));          // raw codes: no folding
		send_beat(feed_beat("7"));

		set_config(MODE_SPARE, 1'b1);
		send_beat(feed_beat("x"));
		send_beat(feed_beat("x"));
		send_beat(read_beat(SYM_W'("x"), SYM_W'("x")));
	endtask

	// One stretch of text under one setting; optionally with no gaps.
	task automatic test_text(input logic [1:0] mode, input logic paired,
			input bit no_gaps, input int beats);
		set_config(mode, paired);
		quiet = no_gaps;
		send_words(mode, beats);
		await_drain();
		quiet = 1'b0;
	endtask

	// Hold the result side off while the feed keeps offering, so the block
	// fills and stalls its input; then pause the feed until all is back.
	task automatic test_backpressure();
		set_config(MODE_LETTER, 1'b0);
		hold_request = 1'b1;
		send_words(MODE_LETTER, 80);
		await_drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_registers();
		test_directed();
		test_text(MODE_LETTER, 1'b0, 1'b0, 290);
		test_text(MODE_DIGIT, 1'b0, 1'b1, 290);
		test_text(MODE_RAW, 1'b1, 1'b0, 290);
		test_text(MODE_SPARE, 1'b0, 1'b0, 290);
		test_text(MODE_LETTER, 1'b1, 1'b0, 290);
		test_text(MODE_DIGIT, 1'b1, 1'b0, 290);
		test_backpressure();

		// watch a little longer for stray result beats
		await_drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("letter_digram_contact_counter_test passed");
		else
			$display("letter_digram_contact_counter_test failed");
		$finish;
	end

endmodule
